@@ hw/rtl/afr_pkg.sv @@
// Shared types and constants for the acknowledge frame receiver.
// Used by afr_core and ack_frame_receiver; no dependencies.
package afr_pkg;

  localparam int unsigned FRAME_LEN   = 10;
  localparam int unsigned LIMIT_W     = 16;
  localparam int unsigned ADDR_W      = 3;
  localparam int unsigned DATA_W      = 32;

  localparam logic [7:0] HDR0 = 8'hB5;
  localparam logic [7:0] HDR1 = 8'h62;
  localparam logic [7:0] HDR2 = 8'h05;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd1500;

  localparam logic [3:0] POS_NAK   = 4'd3;
  localparam logic [3:0] POS_CLASS = 4'd6;
  localparam logic [3:0] POS_ID    = 4'd7;
  localparam logic [3:0] POS_SUMA  = 4'd8;
  localparam logic [3:0] POS_SUMB  = 4'd9;

  typedef enum logic [0:0] {
    REG_TIMEOUT = 1'b0,
    REG_NONE    = 1'b1
  } reg_sel_t;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_BYTE  = 2'd1,
    REQ_TICK  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_ACK      = 2'd0,
    ST_NAK      = 2'd1,
    ST_MISMATCH = 2'd2,
    ST_TIMEOUT  = 2'd3
  } status_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] got_class;
    logic [7:0] got_id;
  } afr_result_t;

  function automatic logic [7:0] hdr_byte(input logic [1:0] pos);
    logic [7:0] b;
    case (pos)
      2'd0:    b = HDR0;
      2'd1:    b = HDR1;
      default: b = HDR2;
    endcase
    return b;
  endfunction

endpackage

@@ hw/rtl/afr_core.sv @@
// Frame state and single-pass item evaluation for the acknowledge receiver.
// Depends on afr_pkg; instantiated by ack_frame_receiver.
module afr_core
  import afr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [1:0]         req_type,
  input  logic [7:0]         expected_class,
  input  logic [7:0]         expected_id,
  input  logic [7:0]         rx_byte,
  input  logic [LIMIT_W-1:0] limit,
  output logic               res_valid,
  output afr_result_t        res
);

  logic               waiting, waiting_next;
  logic [3:0]         position, position_next;
  logic [7:0]         want_class, want_id;
  logic [LIMIT_W-1:0] elapsed, elapsed_next;
  logic [7:0]         sum_a, sum_a_next, sum_b, sum_b_next;
  logic [7:0]         byte6, byte6_next, byte7, byte7_next, byte8, byte8_next;
  logic               start;
  req_t               req;

  assign req   = req_t'(req_type);
  assign start = accept && (req == REQ_START);

  always_comb begin
    waiting_next  = waiting;
    position_next = position;
    elapsed_next  = elapsed;
    sum_a_next    = sum_a;
    sum_b_next    = sum_b;
    byte6_next    = byte6;
    byte7_next    = byte7;
    byte8_next    = byte8;
    res_valid     = 1'b0;
    res           = '{status: ST_ACK, got_class: 8'd0, got_id: 8'd0};
    if (accept && waiting) begin
      case (req)
        REQ_BYTE: begin
          if (position < POS_NAK) begin
            if (rx_byte == hdr_byte(position[1:0])) begin
              position_next = position + 4'd1;
            end
          end else begin
            position_next = position + 4'd1;
            if (position < POS_SUMA) begin
              sum_a_next = sum_a + rx_byte;
              sum_b_next = sum_b + sum_a_next;
            end
            if (position == POS_CLASS) byte6_next = rx_byte;
            if (position == POS_ID)    byte7_next = rx_byte;
            if (position == POS_SUMA)  byte8_next = rx_byte;
          end
          if (position == POS_SUMB) begin
            res_valid     = 1'b1;
            res.got_class = byte6;
            res.got_id    = byte7;
            res.status    = (byte6 == want_class && byte7 == want_id &&
                             byte8 == sum_a && rx_byte == sum_b) ? ST_ACK : ST_MISMATCH;
          end else if (elapsed > limit) begin
            res_valid     = 1'b1;
            res.status    = ST_TIMEOUT;
            res.got_class = (position_next > POS_CLASS) ? byte6_next : 8'd0;
            res.got_id    = (position_next > POS_ID)    ? byte7_next : 8'd0;
          end else if (position == POS_NAK && rx_byte == 8'd0) begin
            res_valid  = 1'b1;
            res.status = ST_NAK;
          end
        end
        REQ_TICK: begin
          if (elapsed != {LIMIT_W{1'b1}}) begin
            elapsed_next = elapsed + 1'b1;
          end
          if (elapsed_next > limit) begin
            res_valid     = 1'b1;
            res.status    = ST_TIMEOUT;
            res.got_class = (position > POS_CLASS) ? byte6 : 8'd0;
            res.got_id    = (position > POS_ID)    ? byte7 : 8'd0;
          end
        end
        default: begin
        end
      endcase
      if (res_valid) begin
        waiting_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      waiting    <= 1'b0;
      position   <= 4'd0;
      elapsed    <= '0;
      want_class <= 8'd0;
      want_id    <= 8'd0;
      sum_a      <= HDR2;
      sum_b      <= HDR2;
    end else if (start) begin
      waiting    <= 1'b1;
      position   <= 4'd0;
      elapsed    <= '0;
      want_class <= expected_class;
      want_id    <= expected_id;
      sum_a      <= HDR2;
      sum_b      <= HDR2;
    end else begin
      waiting    <= waiting_next;
      position   <= position_next;
      elapsed    <= elapsed_next;
      sum_a      <= sum_a_next;
      sum_b      <= sum_b_next;
    end
  end

  always_ff @(posedge clk) begin
    byte6 <= byte6_next;
    byte7 <= byte7_next;
    byte8 <= byte8_next;
  end

endmodule

@@ hw/rtl/ack_frame_receiver.sv @@
// Top level of the acknowledge frame receiver: APB register, item channel,
// result buffer. Depends on afr_pkg and afr_core.
//
// Takes one item (start, received byte or millisecond tick) every clock cycle
// while in_stall is low and evaluates it in a single pass against the stored
// frame state; a result, when an item causes one, is registered into a
// two-entry output buffer, so input beats keep flowing while one result waits;
// in_stall rises only while the second entry is occupied. The only register,
// timeout_limit_ms, lives at byte address 0.
module ack_frame_receiver
  import afr_pkg::*;
#(
  parameter int unsigned TimeoutReset = LIMIT_RESET
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        req_type,
  input  logic [7:0]        expected_class,
  input  logic [7:0]        expected_id,
  input  logic [7:0]        rx_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        status,
  output logic [7:0]        got_class,
  output logic [7:0]        got_id
);

  logic [LIMIT_W-1:0] timeout_limit_ms;
  logic               accept, drain, res_valid, skid_valid;
  afr_result_t        res, out_res, skid_res;
  reg_sel_t           reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = reg_sel_t'(paddr[ADDR_W-1]);

  always_comb begin
    unique case (reg_sel)
      REG_TIMEOUT: prdata = {{(DATA_W-LIMIT_W){1'b0}}, timeout_limit_ms};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit_ms <= LIMIT_W'(TimeoutReset);
    end else if (psel && penable && pwrite && pready && reg_sel == REG_TIMEOUT) begin
      timeout_limit_ms <= pwdata[LIMIT_W-1:0];
    end
  end

  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;
  assign drain    = out_valid && !out_stall;

  afr_core u_core (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .req_type       (req_type),
    .expected_class (expected_class),
    .expected_id    (expected_id),
    .rx_byte        (rx_byte),
    .limit          (timeout_limit_ms),
    .res_valid      (res_valid),
    .res            (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (drain) begin
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid || drain) begin
        out_res   <= res;
        out_valid <= 1'b1;
      end else begin
        skid_res   <= res;
        skid_valid <= 1'b1;
      end
    end else if (drain) begin
      out_valid <= 1'b0;
    end
  end

  assign status    = out_res.status;
  assign got_class = out_res.got_class;
  assign got_id    = out_res.got_id;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("result buffer second entry full while output empty");

  a_result_from_beat: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> accept)
    else $error("result produced without an input beat");

  a_nak_no_bytes: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status == ST_NAK) |-> (res.got_class == 8'd0 && res.got_id == 8'd0))
    else $error("nak result carries frame bytes");

endmodule

@@ bench/ack_result_checker.sv @@
`timescale 1ns / 100ps
// Result checker for ack_frame_receiver: follows item beats, result beats and
// timeout register writes, predicts each frame verdict and compares it.
// Depends on afr_pkg for the field types, codes and frame constants.
module ack_result_checker
  import afr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [1:0]        req_type,
  input  logic [7:0]        expected_class,
  input  logic [7:0]        expected_id,
  input  logic [7:0]        rx_byte,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [1:0]        status,
  input  logic [7:0]        got_class,
  input  logic [7:0]        got_id,
  output int                mismatches,
  output int                pending,
  output int                results_checked
);

  localparam logic [ADDR_W-1:0] TIMEOUT_ADDR = ADDR_W'(4 * int'(REG_TIMEOUT));

  logic [LIMIT_W-1:0] limit_ms;
  logic               waiting;
  logic [3:0]         pos;
  logic [7:0]         frame_bytes [FRAME_LEN];
  logic [7:0]         want_class;
  logic [7:0]         want_id;
  logic [15:0]        elapsed_ms;
  afr_result_t        verdicts [$];

  initial begin
    mismatches = 0;
    pending = 0;
    results_checked = 0;
  end

  function automatic afr_result_t close_wait(status_t st, bit with_bytes);
    afr_result_t r;
    r.status = st;
    r.got_class = (with_bytes && pos > POS_CLASS) ? frame_bytes[POS_CLASS] : 8'h00;
    r.got_id = (with_bytes && pos > POS_ID) ? frame_bytes[POS_ID] : 8'h00;
    waiting = 1'b0;
    return r;
  endfunction

  task automatic load_template();
    foreach (frame_bytes[k]) frame_bytes[k] = 8'h00;
    frame_bytes[0] = HDR0;
    frame_bytes[1] = HDR1;
    frame_bytes[2] = HDR2;
  endtask

  task automatic judge_item(input req_t req, input logic [7:0] cls, input logic [7:0] id,
                            input logic [7:0] b, output bit found, output afr_result_t r);
    logic [7:0] sum_a;
    logic [7:0] sum_b;
    found = 1'b0;
    r = '0;
    sum_a = 8'h00;
    sum_b = 8'h00;
    if (req == REQ_START) begin
      waiting = 1'b1;
      pos = 4'd0;
      load_template();
      want_class = cls;
      want_id = id;
      elapsed_ms = 16'd0;
    end else if (waiting && req == REQ_BYTE) begin
      if (pos < FRAME_LEN) begin
        if (pos < POS_NAK) begin
          if (b == frame_bytes[pos]) pos++;
        end else begin
          frame_bytes[pos] = b;
          pos++;
        end
      end
      found = 1'b1;
      if (pos >= FRAME_LEN) begin
        for (int k = 2; k <= POS_ID; k++) begin
          sum_a += frame_bytes[k];
          sum_b += sum_a;
        end
        r = close_wait((frame_bytes[POS_CLASS] == want_class && frame_bytes[POS_ID] == want_id &&
                        frame_bytes[POS_SUMA] == sum_a && frame_bytes[POS_SUMB] == sum_b) ?
                       ST_ACK : ST_MISMATCH, 1'b1);
      end else if (elapsed_ms > limit_ms) begin
        r = close_wait(ST_TIMEOUT, 1'b1);
      end else if (pos == POS_NAK + 1 && frame_bytes[POS_NAK] == 8'h00) begin
        r = close_wait(ST_NAK, 1'b0);
      end else begin
        found = 1'b0;
      end
    end else if (waiting && req == REQ_TICK) begin
      if (elapsed_ms != 16'hFFFF) elapsed_ms++;
      if (elapsed_ms > limit_ms) begin
        found = 1'b1;
        r = close_wait(ST_TIMEOUT, 1'b1);
      end
    end
  endtask

  always @(posedge clk) begin
    bit          found;
    afr_result_t r;
    afr_result_t want;
    if (rst) begin
      limit_ms = LIMIT_RESET;
      waiting = 1'b0;
      pos = 4'd0;
      load_template();
      want_class = 8'h00;
      want_id = 8'h00;
      elapsed_ms = 16'd0;
      verdicts.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == TIMEOUT_ADDR)
        limit_ms = pwdata[LIMIT_W-1:0];
      if (in_valid && !in_stall) begin
        judge_item(req_t'(req_type), expected_class, expected_id, rx_byte, found, r);
        if (found) verdicts.push_back(r);
      end
      if (out_valid && !out_stall) begin
        results_checked++;
        if (verdicts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("verdict %0d: none expected, got status %0d class %02h id %02h",
                     results_checked, status, got_class, got_id);
        end else begin
          want = verdicts.pop_front();
          if (status !== want.status || got_class !== want.got_class ||
              got_id !== want.got_id) begin
            mismatches++;
            if (mismatches <= 10)
              $display("verdict %0d: expected %s class %02h id %02h, got %0d class %02h id %02h",
                       results_checked, want.status.name(), want.got_class, want.got_id,
                       status, got_class, got_id);
          end
        end
      end
    end
    pending = verdicts.size();
  end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// Top of the ack_frame_receiver bench: clock, reset, timeout register writes and
// item beats under changing traffic mixes, then the verdict.
// Depends on afr_pkg, ack_frame_receiver and ack_result_checker.
module testbench;
  import afr_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 4;
  localparam logic [ADDR_W-1:0] TIMEOUT_ADDR = ADDR_W'(4 * int'(REG_TIMEOUT));

  typedef enum int {
    FR_GOOD,
    FR_BAD_CLASS,
    FR_BAD_ID,
    FR_BAD_SUMA,
    FR_BAD_SUMB,
    FR_NAK
  } frame_kind_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        req_type = '0;
  logic [7:0]        expected_class = '0;
  logic [7:0]        expected_id = '0;
  logic [7:0]        rx_byte = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        status;
  logic [7:0]        got_class;
  logic [7:0]        got_id;

  int mismatches;
  int pending;
  int results_checked;
  int send_pct = 0;
  int recv_pct = 0;
  int cur_limit = LIMIT_RESET;
  int wait_ticks = 0;
  int items_sent = 0;
  int beats_sent = 0;
  int limit_writes = 0;
  int cycle_count = 0;
  logic [7:0] frame_out [FRAME_LEN];

  ack_frame_receiver DUT (.*);

  ack_result_checker results_check (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_pct);

  task automatic send_item(req_t req, logic [7:0] cls, logic [7:0] id, logic [7:0] b);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    expected_class <= cls;
    expected_id <= id;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    items_sent++;
    beats_sent++;
    if (req == REQ_START) wait_ticks = 0;
    if (req == REQ_TICK) wait_ticks++;
  endtask

  task automatic send_start(logic [7:0] cls, logic [7:0] id);
    send_item(REQ_START, cls, id, 8'($urandom));
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(REQ_BYTE, 8'($urandom), 8'($urandom), b);
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_item(REQ_TICK, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 3);
    repeat (n) begin
      send_item(req_t'(2'($urandom_range(1, 3))), 8'($urandom), 8'($urandom), 8'($urandom));
      items_sent--;
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_limit(int value);
    drain_results();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= TIMEOUT_ADDR;
    pwdata <= DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cur_limit = value;
    limit_writes++;
  endtask

  function automatic void build_frame(logic [7:0] cls, logic [7:0] id, frame_kind_t kind);
    logic [7:0] sum_a;
    logic [7:0] sum_b;
    frame_out[0] = HDR0;
    frame_out[1] = HDR1;
    frame_out[2] = HDR2;
    frame_out[3] = (kind == FR_NAK) ? 8'h00 : 8'($urandom_range(1, 255));
    frame_out[4] = 8'($urandom);
    frame_out[5] = 8'($urandom);
    frame_out[6] = cls ^ ((kind == FR_BAD_CLASS) ? 8'($urandom_range(1, 255)) : 8'h00);
    frame_out[7] = id ^ ((kind == FR_BAD_ID) ? 8'($urandom_range(1, 255)) : 8'h00);
    sum_a = 8'h00;
    sum_b = 8'h00;
    for (int k = 2; k < 8; k++) begin
      sum_a += frame_out[k];
      sum_b += sum_a;
    end
    frame_out[8] = sum_a ^ ((kind == FR_BAD_SUMA) ? 8'($urandom_range(1, 255)) : 8'h00);
    frame_out[9] = sum_b ^ ((kind == FR_BAD_SUMB) ? 8'($urandom_range(1, 255)) : 8'h00);
  endfunction

  // slip a tick between bytes now and then, never enough to time out
  task automatic send_bytes(int first, int last);
    for (int k = first; k < last; k++) begin
      if (wait_ticks < cur_limit && $urandom_range(9) == 0) send_ticks(1);
      send_byte(frame_out[k]);
    end
  endtask

  task automatic run_frame_exchange();
    logic [7:0]  cls;
    logic [7:0]  id;
    logic [7:0]  b;
    frame_kind_t kind;
    int          pick;
    cls = 8'($urandom);
    id = 8'($urandom);
    send_start(cls, id);
    if ($urandom_range(99) < 25) begin
      repeat ($urandom_range(1, 3)) begin
        b = 8'($urandom);
        send_byte((b == HDR0) ? 8'h00 : b);
      end
    end
    pick = $urandom_range(99);
    if (pick < 72) begin
      if (pick < 40) kind = FR_GOOD;
      else if (pick < 50) kind = FR_BAD_CLASS;
      else if (pick < 58) kind = FR_BAD_ID;
      else if (pick < 65) kind = FR_BAD_SUMA;
      else kind = FR_BAD_SUMB;
      build_frame(cls, id, kind);
      send_bytes(0, FRAME_LEN);
    end else if (pick < 80) begin
      build_frame(cls, id, FR_NAK);
      send_bytes(0, POS_NAK + 1);
    end else if (pick < 92) begin
      build_frame(cls, id, FR_GOOD);
      send_bytes(0, $urandom_range(0, 9));
      if (cur_limit < 100) send_ticks(cur_limit + 1 - wait_ticks);
    end else begin
      build_frame(cls, id, FR_GOOD);
      send_bytes(0, $urandom_range(1, 9));
      cls = 8'($urandom);
      id = 8'($urandom);
      send_start(cls, id);
      build_frame(cls, id, FR_GOOD);
      send_bytes(0, FRAME_LEN);
    end
  endtask

  initial begin
    int target;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // finish a frame on the reset limit, then feed items to an idle block
    send_start(8'hFF, 8'h00);
    send_ticks(3);
    build_frame(8'hFF, 8'h00, FR_GOOD);
    send_bytes(0, FRAME_LEN);
    send_byte(HDR0);
    send_ticks(1);
    send_item(REQ_NONE, 8'hFF, 8'hFF, 8'hFF);

    set_limit(0);
    send_start(8'h00, 8'hFF);
    send_ticks(1);

    set_limit(65535);
    send_start(8'hFF, 8'hFF);
    build_frame(8'hFF, 8'hFF, FR_GOOD);
    send_bytes(0, FRAME_LEN);

    send_start(8'h06, 8'h01);
    build_frame(8'h06, 8'h01, FR_NAK);
    send_bytes(0, POS_NAK + 1);

    // a stray byte inside the header is dropped without losing the match
    send_start(8'h13, 8'h37);
    send_byte(HDR0);
    send_byte(8'h33);
    build_frame(8'h13, 8'h37, FR_GOOD);
    send_bytes(0, FRAME_LEN);

    send_start(8'h01, 8'h02);
    build_frame(8'h01, 8'h02, FR_GOOD);
    send_bytes(0, 5);
    send_start(8'h03, 8'h04);
    build_frame(8'h03, 8'h04, FR_BAD_SUMB);
    send_bytes(0, FRAME_LEN);

    // lower the limit mid-wait: last byte completes, then byte and tick time out
    set_limit(1500);
    send_start(8'h05, 8'h06);
    build_frame(8'h05, 8'h06, FR_GOOD);
    send_bytes(0, FRAME_LEN - 1);
    send_ticks(3);
    set_limit(2);
    send_bytes(FRAME_LEN - 1, FRAME_LEN);

    set_limit(65535);
    send_start(8'h07, 8'h08);
    build_frame(8'h07, 8'h08, FR_GOOD);
    send_bytes(0, POS_SUMA);
    send_ticks(3);
    set_limit(1);
    send_bytes(POS_SUMA, POS_SUMB);

    set_limit(65535);
    send_start(8'h5A, 8'hA5);
    send_ticks(5);
    set_limit(2);
    send_ticks(1);

    for (int half = 0; half < 8; half++) begin
      case (half / 2)
        0: begin
          send_pct = 0;
          recv_pct = 0;
        end
        1: begin
          send_pct = 82;
          recv_pct = 0;
        end
        2: begin
          send_pct = 0;
          recv_pct = 82;
        end
        default: begin
          send_pct = 7;
          recv_pct = 7;
        end
      endcase
      case (half)
        0: set_limit(1);
        1: set_limit(65535);
        2: set_limit($urandom_range(2, 12));
        3: set_limit($urandom_range(20, 60));
        4: set_limit($urandom_range(2, 8));
        5: set_limit($urandom_range(1, 20));
        6: set_limit($urandom_range(5, 30));
        default: set_limit($urandom_range(61, 99));
      endcase
      target = items_sent + 35;
      while (items_sent < target) begin
        if ($urandom_range(99) < 8) send_noise();
        run_frame_exchange();
      end
    end

    drain_results();
    $display("Ran %0d item beats over four traffic mixes with %0d timeout limit writes.",
             beats_sent, limit_writes);
    $display("Compared %0d frame verdicts field by field.", results_checked);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/afr_pkg.sv
hw/rtl/afr_core.sv
hw/rtl/ack_frame_receiver.sv
bench/ack_result_checker.sv
bench/testbench.sv
